>>> rtl/selective_repeat_sender_top_assert.svh
// ----------------------------------------------------------------------------
// Selective repeat sender assertion macros
// Shared property forms used by the sender RTL. Each expects signals named
// clock and reset in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SRS_ASSERT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// Selective repeat sender package
// Widths, codes, payload types and the slot table interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

   // Window sizing
   localparam int WINDOW_MAX  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Time stamp: valid bit over a 16-bit tick value
   localparam int TICK_W  = 16;
   localparam int STAMP_W = TICK_W + 1;

   // Register map
   localparam logic REG_WIN_SLOTS = 1'b0;
   localparam logic REG_TIMEOUT   = 1'b1;

   localparam logic [4:0]  WIN_SLOTS_RESET = 5'd4;
   localparam logic [14:0] TIMEOUT_RESET   = 15'd500;

   // Packet codes
   localparam logic [1:0] PKT_TYPE_ACK = 2'd3;
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_DATA    = 2'd2;

   typedef struct packed {
      logic        func;
      logic [1:0]  pkt_type;
      logic [31:0] pkt_seq;
      logic        crc_ok;
      logic [4:0]  segments_ready;
      logic        source_done;
   } srs_req_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [31:0] send_seq;
      logic        is_resend;
      logic        transfer_done;
      logic        last;
   } srs_rsp_type;

   // Commands from the sequencer to the slot table
   typedef struct packed {
      logic               shift;
      logic               ack_wr;
      logic [IDX_W-1:0]   ack_idx;
      logic               scan_wr;
      logic [IDX_W-1:0]   scan_idx;
      logic [STAMP_W-1:0] stamp;
   } slot_cmd_type;

   // Status from the slot table
   typedef struct packed {
      logic               head_acked;
      logic               any_filled;
      logic               entry_acked;
      logic               entry_filled;
      logic [STAMP_W-1:0] entry_stamp;
   } slot_stat_type;

endpackage

`default_nettype wire

>>> rtl/srs_slot_table.sv
// ----------------------------------------------------------------------------
// Selective repeat sender slot table
// Per-slot acked and filled flags plus send time stamps, kept by offset from
// the window base. Shifts down one slot per cycle while the base slides.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_slot_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srs_pkg::slot_cmd_type cmd,
   output srs_pkg::slot_stat_type     stat
);

   logic [srs_pkg::WINDOW_MAX-1:0] acked_ff;
   logic [srs_pkg::WINDOW_MAX-1:0] filled_ff;
   logic [srs_pkg::STAMP_W-1:0]    stamp_ff [srs_pkg::WINDOW_MAX];

   // Slot storage: shift on slide, else ack mark or scan update
   always_ff @(posedge clock) begin
      if (reset) begin
         acked_ff  <= '0;
         filled_ff <= '0;
         for (int k = 0; k < srs_pkg::WINDOW_MAX; k++) begin
            stamp_ff[k] <= '0;
         end
      end else if (cmd.shift) begin
         for (int k = 0; k + 1 < srs_pkg::WINDOW_MAX; k++) begin
            acked_ff[k]  <= acked_ff[k+1];
            filled_ff[k] <= filled_ff[k+1];
            stamp_ff[k]  <= stamp_ff[k+1];
         end
         acked_ff[srs_pkg::WINDOW_MAX-1]  <= 1'b0;
         filled_ff[srs_pkg::WINDOW_MAX-1] <= 1'b0;
         stamp_ff[srs_pkg::WINDOW_MAX-1]  <= '0;
      end else begin
         if (cmd.ack_wr) begin
            acked_ff[cmd.ack_idx] <= 1'b1;
            stamp_ff[cmd.ack_idx] <= cmd.stamp;
         end
         if (cmd.scan_wr) begin
            filled_ff[cmd.scan_idx] <= 1'b1;
            stamp_ff[cmd.scan_idx]  <= cmd.stamp;
         end
      end
   end

   // Status toward the sequencer
   assign stat.head_acked   = acked_ff[0];
   assign stat.any_filled   = |filled_ff;
   assign stat.entry_acked  = acked_ff[cmd.scan_idx];
   assign stat.entry_filled = filled_ff[cmd.scan_idx];
   assign stat.entry_stamp  = stamp_ff[cmd.scan_idx];

endmodule

`default_nettype wire

>>> rtl/selective_repeat_sender_top.sv
// ----------------------------------------------------------------------------
// Selective repeat sender
// Sender-side ARQ controller: START handshake, windowed data sends with
// per-slot timeouts and selective resend, END handshake.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  srs_req_type (tick or packet)
//   rsp      out        rsp_valid/rsp_stall  srs_rsp_type (send command)
//   csr      in/out     psel/penable/pready  window slots, timeout_ticks
//
// An item in start, end or done phase passes the control and flush states; a
// START ACK goes on as a data-phase item. A data-phase item passes control,
// ACK mark, slide, check, scan and flush (check goes to flush when it sends
// END): window slots visited one per cycle by the shared timeout compare
// unless rsp_stall holds the output register, acked slots slid out one per
// cycle after an ACK. Synchronous reset clears phase, base, ticks and all slots.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_sender_top_assert.svh"

module selective_repeat_sender_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input item channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire srs_pkg::srs_req_type req_data,
   // Result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output srs_pkg::srs_rsp_type      rsp_data,
   // Configuration port
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_CTRL, S_ACK, S_SLIDE, S_CHECK, S_SCAN, S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      PH_START, PH_DATA, PH_END, PH_DONE
   } phase_type;

   localparam int CNT_W = srs_pkg::CNT_W;
   localparam logic [srs_pkg::RES_CNT_W-1:0] RES_LIMIT =
      srs_pkg::RES_CNT_W'(srs_pkg::MAX_RESULTS);

   // Configuration registers
   logic [4:0]  win_size_ff;
   logic [14:0] timeout_ff;

   // Sequencer state
   state_type                    state_ff, state_in;
   phase_type                    phase_ff, phase_in;
   logic [31:0]                  base_ff, base_in;
   logic [srs_pkg::TICK_W-1:0]   now_ff, now_in;
   logic [srs_pkg::STAMP_W-1:0]  ctrl_stamp_ff, ctrl_stamp_in;
   srs_pkg::srs_req_type         item_ff, item_in;
   logic                         ack_data_ff, ack_data_in;
   logic [CNT_W-1:0]             scan_idx_ff, scan_idx_in;
   logic [srs_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [4:0]                   avail_ff, avail_in;
   logic                         pend_valid_ff, pend_valid_in;
   srs_pkg::srs_rsp_type         pend_data_ff, pend_data_in;
   logic                         rsp_valid_ff;
   srs_pkg::srs_rsp_type         rsp_data_ff;

   srs_pkg::slot_cmd_type        slot_cmd;
   srs_pkg::slot_stat_type       slot_stat;

   logic                         cfg_wr;
   logic [CNT_W-1:0]             win;
   logic                         is_ack;
   logic [srs_pkg::STAMP_W-1:0]  now_stamp;
   logic [srs_pkg::STAMP_W-1:0]  tmo_stamp;
   logic [srs_pkg::TICK_W-1:0]   elapsed;
   logic                         timed_out;
   logic [31:0]                  ack_off;
   logic [31:0]                  scan_seq;
   logic                         out_free;
   logic                         can_emit;
   logic                         emit_req;
   srs_pkg::srs_rsp_type         emit_data;
   logic                         push;
   srs_pkg::srs_rsp_type         push_data;
   logic                         slide_step;

   // Configuration write and read-back
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= srs_pkg::WIN_SLOTS_RESET;
         timeout_ff  <= srs_pkg::TIMEOUT_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == srs_pkg::REG_WIN_SLOTS) begin
            win_size_ff <= pwdata[4:0];
         end else begin
            timeout_ff <= pwdata[14:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == srs_pkg::REG_TIMEOUT) begin
         prdata = {17'd0, timeout_ff};
      end else begin
         prdata = {27'd0, win_size_ff};
      end
   end

   // Active window: zero acts as one, clamp to the slot count
   always_comb begin
      if (win_size_ff == 5'd0) begin
         win = CNT_W'(1);
      end else if (int'(win_size_ff) > srs_pkg::WINDOW_MAX) begin
         win = CNT_W'(srs_pkg::WINDOW_MAX);
      end else begin
         win = CNT_W'(int'(win_size_ff));
      end
   end

   assign is_ack = item_ff.func && item_ff.crc_ok &&
                   (item_ff.pkt_type == srs_pkg::PKT_TYPE_ACK);
   assign now_stamp = {1'b1, now_ff};

   // Shared timeout unit: control stamp or the slot under scan
   assign tmo_stamp = (state_ff == S_SCAN) ? slot_stat.entry_stamp : ctrl_stamp_ff;
   assign elapsed   = now_ff - tmo_stamp[srs_pkg::TICK_W-1:0];
   assign timed_out = tmo_stamp[srs_pkg::STAMP_W-1] &&
                      (elapsed > {1'b0, timeout_ff});

   assign ack_off  = item_ff.pkt_seq - base_ff;
   assign scan_seq = base_ff + 32'(scan_idx_ff);

   assign slide_step = (state_ff == S_SLIDE) && slot_stat.head_acked;

   // Output register frees when empty or taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit = !pend_valid_ff || out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      base_in       = base_ff;
      now_in        = now_ff;
      ctrl_stamp_in = ctrl_stamp_ff;
      item_in       = item_ff;
      ack_data_in   = ack_data_ff;
      scan_idx_in   = scan_idx_ff;
      res_cnt_in    = res_cnt_ff;
      avail_in      = avail_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      emit_req      = 1'b0;
      emit_data     = '0;
      push          = 1'b0;
      push_data     = pend_data_ff;
      slot_cmd          = '0;
      slot_cmd.scan_idx = scan_idx_ff[srs_pkg::IDX_W-1:0];
      slot_cmd.stamp    = now_stamp;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (!req_data.func) begin
                  now_in = now_ff + srs_pkg::TICK_W'(1);
               end
               state_in = S_CTRL;
            end
         end

         // Control handshake phases
         S_CTRL: begin
            case (phase_ff)
               PH_START: begin
                  if (is_ack && ctrl_stamp_ff[srs_pkg::STAMP_W-1]) begin
                     phase_in    = PH_DATA;
                     ack_data_in = 1'b0;
                     state_in    = S_ACK;
                  end else if (!ctrl_stamp_ff[srs_pkg::STAMP_W-1] || timed_out) begin
                     emit_req            = 1'b1;
                     emit_data.send_kind = srs_pkg::KIND_START;
                     emit_data.is_resend = ctrl_stamp_ff[srs_pkg::STAMP_W-1];
                     if (can_emit) begin
                        ctrl_stamp_in = now_stamp;
                        state_in      = S_FLUSH;
                     end
                  end else begin
                     state_in = S_FLUSH;
                  end
               end
               PH_DATA: begin
                  ack_data_in = is_ack;
                  state_in    = S_ACK;
               end
               PH_END: begin
                  if (is_ack && (item_ff.pkt_seq == 32'd0)) begin
                     emit_req                = 1'b1;
                     emit_data.transfer_done = 1'b1;
                     if (can_emit) begin
                        phase_in = PH_DONE;
                        state_in = S_FLUSH;
                     end
                  end else if (timed_out) begin
                     emit_req            = 1'b1;
                     emit_data.send_kind = srs_pkg::KIND_END;
                     emit_data.is_resend = 1'b1;
                     if (can_emit) begin
                        ctrl_stamp_in = now_stamp;
                        state_in      = S_FLUSH;
                     end
                  end else begin
                     state_in = S_FLUSH;
                  end
               end
               default: begin
                  state_in = S_FLUSH;
               end
            endcase
         end

         // In-window ACK marks its slot
         S_ACK: begin
            if (ack_data_ff && (ack_off < 32'(win))) begin
               slot_cmd.ack_wr  = 1'b1;
               slot_cmd.ack_idx = ack_off[srs_pkg::IDX_W-1:0];
            end
            state_in = S_SLIDE;
         end

         // Slide the base over acked head slots, one per cycle
         S_SLIDE: begin
            if (slot_stat.head_acked) begin
               slot_cmd.shift = 1'b1;
               base_in        = base_ff + 32'd1;
            end else begin
               state_in = S_CHECK;
            end
         end

         // End of data or start of the window scan
         S_CHECK: begin
            if (!slot_stat.any_filled && item_ff.source_done) begin
               emit_req            = 1'b1;
               emit_data.send_kind = srs_pkg::KIND_END;
               if (can_emit) begin
                  phase_in      = PH_END;
                  ctrl_stamp_in = now_stamp;
                  state_in      = S_FLUSH;
               end
            end else begin
               avail_in    = item_ff.source_done ? 5'd0 : item_ff.segments_ready;
               scan_idx_in = '0;
               res_cnt_in  = '0;
               state_in    = S_SCAN;
            end
         end

         // One slot per cycle unless rsp_stall holds a result: new sends and timed-out resends
         S_SCAN: begin
            if ((scan_idx_ff >= win) || (res_cnt_ff == RES_LIMIT)) begin
               state_in = S_FLUSH;
            end else if (slot_stat.entry_acked) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end else if (!slot_stat.entry_filled) begin
               if (avail_ff == 5'd0) begin
                  scan_idx_in = scan_idx_ff + CNT_W'(1);
               end else begin
                  emit_req            = 1'b1;
                  emit_data.send_kind = srs_pkg::KIND_DATA;
                  emit_data.send_seq  = scan_seq;
                  if (can_emit) begin
                     avail_in         = avail_ff - 5'd1;
                     slot_cmd.scan_wr = 1'b1;
                     res_cnt_in       = res_cnt_ff + srs_pkg::RES_CNT_W'(1);
                     scan_idx_in      = scan_idx_ff + CNT_W'(1);
                  end
               end
            end else if (timed_out) begin
               emit_req            = 1'b1;
               emit_data.send_kind = srs_pkg::KIND_DATA;
               emit_data.send_seq  = scan_seq;
               emit_data.is_resend = 1'b1;
               if (can_emit) begin
                  slot_cmd.scan_wr = 1'b1;
                  res_cnt_in       = res_cnt_ff + srs_pkg::RES_CNT_W'(1);
                  scan_idx_in      = scan_idx_ff + CNT_W'(1);
               end
            end else begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end

         // Release the held result marked last
         S_FLUSH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  push           = 1'b1;
                  push_data      = pend_data_ff;
                  push_data.last = 1'b1;
                  pend_valid_in  = 1'b0;
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A new result moves the held one out, not last
      if (emit_req && can_emit) begin
         push          = pend_valid_ff;
         push_data     = pend_data_ff;
         pend_valid_in = 1'b1;
         pend_data_in  = emit_data;
      end
   end

   // Sequencer registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_START;
         base_ff       <= '0;
         now_ff        <= '0;
         ctrl_stamp_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         base_ff       <= base_in;
         now_ff        <= now_in;
         ctrl_stamp_ff <= ctrl_stamp_in;
         pend_valid_ff <= pend_valid_in;
         if (out_free) begin
            rsp_valid_ff <= push;
         end
      end
      item_ff      <= item_in;
      ack_data_ff  <= ack_data_in;
      scan_idx_ff  <= scan_idx_in;
      res_cnt_ff   <= res_cnt_in;
      avail_ff     <= avail_in;
      pend_data_ff <= pend_data_in;
      if (out_free && push) begin
         rsp_data_ff <= push_data;
      end
   end

   srs_slot_table u_slots (
      .clock (clock),
      .reset (reset),
      .cmd   (slot_cmd),
      .stat  (slot_stat)
   );

   // Checks on sequencer behavior
   `SRS_ASSERT_HOLDS(a_idle_no_pend, state_ff == S_IDLE, !pend_valid_ff, "held result at idle")
   `SRS_ASSERT_HOLDS(a_scan_in_window, state_ff == S_SCAN, scan_idx_ff <= win, "scan past window")
   `SRS_ASSERT_HOLDS(a_res_limit, state_ff == S_SCAN, res_cnt_ff <= RES_LIMIT, "too many results")
   `SRS_ASSERT_HOLDS(a_done_status, pend_valid_ff && phase_ff == PH_DONE, pend_data_ff.transfer_done, "no done")
   `SRS_ASSERT_NEXT(a_slide_base, slide_step, base_ff == $past(base_ff) + 32'd1, "base did not slide")

endmodule

`default_nettype wire
